/* hdl/ptts_pkg.sv */
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes of the periodic task tick scheduler: commands,
// slot modes, status codes and the controller to datapath interface.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MASK_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4,
    CMD_WAIT    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_EMPTY     = 3'd0,
    MODE_READY     = 3'd1,
    MODE_SUSPENDED = 3'd2,
    MODE_WAITING   = 3'd3,
    MODE_REMOVED   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SLOT   = 2'd1,
    ST_NO_HANDLER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_WALK = 2'd1,
    CS_EXEC = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic walk;
    logic exec;
  } ptts_cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic walk_last;
  } ptts_stat_t;

endpackage

/* hdl/ptts_ctrl.sv */
// ----------------------------------------------------------------------------
// ptts_ctrl
// Controller of the scheduler. Accepts a request, sequences the slot walk
// of a tick or the single update of a slot command, and raises the result
// strobe.
// ----------------------------------------------------------------------------
module ptts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ptts_pkg::ptts_stat_t stat_i,
  output ptts_pkg::ptts_cmd_t  cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import ptts_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.in_is_tick ? CS_WALK : CS_EXEC;
        end
      end
      CS_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_last) begin
          done_d  = 1'b1;
          state_d = CS_IDLE;
        end
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != CS_IDLE);
  assign done_o = done_q;

endmodule

/* hdl/ptts_datapath.sv */
// ----------------------------------------------------------------------------
// ptts_datapath
// Slot table and request registers of the scheduler. Walks one slot per
// cycle on a tick and updates at most one slot on the other commands.
// ----------------------------------------------------------------------------
module ptts_datapath #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptts_pkg::ptts_cmd_t           cmd_i,
  output ptts_pkg::ptts_stat_t          stat_o,
  input  logic [ptts_pkg::CMD_W-1:0]    command_i,
  input  logic [ptts_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptts_pkg::PERIOD_W-1:0] period_i,
  input  logic                          has_handler_i,
  output logic [ptts_pkg::STATUS_W-1:0] status_o,
  output logic [ptts_pkg::MASK_W-1:0]   fired_mask_o,
  output logic                          idle_o
);
  import ptts_pkg::*;

  localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic [PERIOD_W-1:0] period_q [TASK_SLOTS];
  logic [PERIOD_W-1:0] count_q  [TASK_SLOTS];
  mode_e               mode_q   [TASK_SLOTS];
  logic                hp_q     [TASK_SLOTS];

  logic [CMD_W-1:0]    req_cmd_q;
  logic [SLOT_W-1:0]   req_slot_q;
  logic [PERIOD_W-1:0] req_period_q;
  logic                req_hp_q;
  logic [IDX_W-1:0]    walk_idx_q;
  logic [MASK_W-1:0]   mask_acc_q;
  logic                any_acc_q;
  logic [STATUS_W-1:0] status_q;
  logic [MASK_W-1:0]   mask_q;
  logic                idle_q;

  logic [IDX_W-1:0]    rd_idx;
  logic [PERIOD_W-1:0] cur_period;
  logic [PERIOD_W-1:0] cur_count;
  mode_e               cur_mode;
  logic                cur_hp;
  logic                slot_ok;
  logic                step_ready;
  logic [PERIOD_W-1:0] dec_count;
  logic                step_zero;
  logic                step_fire;
  logic [MASK_W-1:0]   step_bit;
  logic                walk_last;

  assign slot_ok    = ({1'b0, req_slot_q} < (SLOT_W+1)'(TASK_SLOTS));
  assign rd_idx     = cmd_i.walk ? walk_idx_q : req_slot_q[IDX_W-1:0];
  assign cur_period = period_q[rd_idx];
  assign cur_count  = count_q[rd_idx];
  assign cur_mode   = mode_q[rd_idx];
  assign cur_hp     = hp_q[rd_idx];

  assign step_ready = (cur_mode == MODE_READY);
  assign dec_count  = cur_count - 1'b1;
  assign step_zero  = (dec_count == '0);
  assign step_fire  = step_ready && step_zero && cur_hp;
  assign step_bit   = step_fire ? (MASK_W'(1) << walk_idx_q) : '0;
  assign walk_last  = (walk_idx_q == IDX_W'(TASK_SLOTS - 1));

  assign stat_o.in_is_tick = (command_i == CMD_TICK);
  assign stat_o.walk_last  = walk_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_cmd_q    <= command_i;
      req_slot_q   <= slot_i;
      req_period_q <= period_i;
      req_hp_q     <= has_handler_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_idx_q <= '0;
      mask_acc_q <= '0;
      any_acc_q  <= 1'b0;
    end else if (cmd_i.load) begin
      walk_idx_q <= '0;
      mask_acc_q <= '0;
      any_acc_q  <= 1'b0;
    end else if (cmd_i.walk) begin
      walk_idx_q <= walk_idx_q + 1'b1;
      mask_acc_q <= mask_acc_q | step_bit;
      any_acc_q  <= any_acc_q | step_fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        period_q[i] <= '0;
        count_q[i]  <= '0;
        mode_q[i]   <= MODE_EMPTY;
        hp_q[i]     <= 1'b0;
      end
    end else if (cmd_i.walk) begin
      if (step_ready) begin
        count_q[rd_idx] <= step_zero ? cur_period : dec_count;
      end
    end else if (cmd_i.exec && slot_ok) begin
      case (req_cmd_q)
        CMD_CREATE: begin
          if (req_hp_q) begin
            period_q[rd_idx] <= req_period_q;
            count_q[rd_idx]  <= PERIOD_W'(1);
            hp_q[rd_idx]     <= 1'b1;
            mode_q[rd_idx]   <= MODE_READY;
          end
        end
        CMD_DELETE: begin
          if (cur_hp) begin
            period_q[rd_idx] <= '0;
            count_q[rd_idx]  <= '0;
            hp_q[rd_idx]     <= 1'b0;
            mode_q[rd_idx]   <= MODE_REMOVED;
          end
        end
        CMD_SUSPEND: mode_q[rd_idx] <= MODE_SUSPENDED;
        CMD_RESUME:  mode_q[rd_idx] <= MODE_READY;
        CMD_WAIT:    mode_q[rd_idx] <= MODE_WAITING;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk && walk_last) begin
      status_q <= ST_OK;
      mask_q   <= mask_acc_q | step_bit;
      idle_q   <= !(any_acc_q || step_fire);
    end else if (cmd_i.exec) begin
      mask_q <= '0;
      idle_q <= 1'b0;
      case (req_cmd_q)
        CMD_CREATE: begin
          if (!slot_ok) begin
            status_q <= ST_BAD_SLOT;
          end else if (!req_hp_q) begin
            status_q <= ST_NO_HANDLER;
          end else begin
            status_q <= ST_OK;
          end
        end
        CMD_DELETE: begin
          if (!slot_ok) begin
            status_q <= ST_BAD_SLOT;
          end else if (!cur_hp) begin
            status_q <= ST_NO_HANDLER;
          end else begin
            status_q <= ST_OK;
          end
        end
        CMD_SUSPEND, CMD_RESUME, CMD_WAIT: begin
          status_q <= slot_ok ? ST_OK : ST_BAD_SLOT;
        end
        default: status_q <= ST_OK;
      endcase
    end
  end

  assign status_o     = status_q;
  assign fired_mask_o = mask_q;
  assign idle_o       = idle_q;

endmodule

/* hdl/periodic_task_tick_scheduler.sv */
// A slot command passes from the idle state through the exec state before the
// registered result strobe; a tick instead passes through the walk state, which
// walks the slot table one slot per cycle through one read port. A new request is
// taken only while the controller is idle, that is while busy is low.
// Reset clears the slot table to empty slots and the controller to idle;
// the receiver cannot stall, so a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Top level of the periodic task tick scheduler: controller plus slot
// table datapath.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptts_pkg::CMD_W-1:0]    command_i,
  input  logic [ptts_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptts_pkg::PERIOD_W-1:0] period_i,
  input  logic                          has_handler_i,
  output logic                          done_o,
  output logic [ptts_pkg::STATUS_W-1:0] status_o,
  output logic [ptts_pkg::MASK_W-1:0]   fired_mask_o,
  output logic                          idle_o
);
  import ptts_pkg::*;

  ptts_cmd_t  cmd;
  ptts_stat_t stat;

  ptts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  ptts_datapath #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .command_i    (command_i),
    .slot_i       (slot_i),
    .period_i     (period_i),
    .has_handler_i(has_handler_i),
    .status_o     (status_o),
    .fired_mask_o (fired_mask_o),
    .idle_o       (idle_o)
  );

endmodule

/* hdl/ptts_checker.sv */
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks of the periodic task tick scheduler, bound to the top
// level.
// ----------------------------------------------------------------------------
module ptts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [ptts_pkg::CMD_W-1:0]    command_i,
  input logic                          done_o,
  input logic [ptts_pkg::STATUS_W-1:0] status_o,
  input logic [ptts_pkg::MASK_W-1:0]   fired_mask_o,
  input logic                          idle_o
);
  import ptts_pkg::*;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_cmd_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i != CMD_TICK) |-> ##2 done_o)
    else $error("slot command result not on time");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_BAD_SLOT
                || status_o == ST_NO_HANDLER))
    else $error("undefined status code");

  a_fired_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fired_mask_o != '0) |-> !idle_o)
    else $error("idle raised with fired slots");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

/* tb/tb_periodic_task_tick_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Self-checking testbench for the periodic task tick scheduler. A queued
// driver issues directed and random slot commands and ticks with random idle
// bursts, a behavioral scoreboard tracks the slot table, and a monitor checks
// every result strobe against the predicted status, fired mask and idle flag.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;
  import ptts_pkg::*;

  localparam int unsigned TASK_SLOTS = 8;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam int unsigned RANDOM_REQS = 450;
  localparam int unsigned CALM_TAIL = 40;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                has_handler;
  } request_t;

  typedef struct {
    status_e           status;
    logic [MASK_W-1:0] fired_mask;
    logic              idle;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    command_i = '0;
  logic [SLOT_W-1:0]   slot_i = '0;
  logic [PERIOD_W-1:0] period_i = '0;
  logic                has_handler_i = 1'b0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [MASK_W-1:0]   fired_mask_o;
  logic                idle_o;

  request_t request_q[$];
  outcome_t outcome_q[$];
  request_t in_flight;
  outcome_t seen_exp;
  int unsigned gap_left = 0;
  int unsigned err_cnt = 0;

  logic [PERIOD_W-1:0] period_tbl[TASK_SLOTS];
  logic [PERIOD_W-1:0] countdown_tbl[TASK_SLOTS];
  mode_e               mode_tbl[TASK_SLOTS];
  logic                handler_tbl[TASK_SLOTS];

  periodic_task_tick_scheduler #(
    .TASK_SLOTS(TASK_SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .slot_i       (slot_i),
    .period_i     (period_i),
    .has_handler_i(has_handler_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .fired_mask_o (fired_mask_o),
    .idle_o       (idle_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the slot table and returns the result it produces.
  function automatic outcome_t scheduler_outcome(request_t req);
    outcome_t res;
    logic any_fired;
    int unsigned idx;
    res = '{status: ST_OK, fired_mask: '0, idle: 1'b0};
    any_fired = 1'b0;
    idx = 32'(req.slot);
    case (req.command)
      CMD_TICK: begin
        for (int s = 0; s < TASK_SLOTS; s++) begin
          if (mode_tbl[s] == MODE_READY) begin
            countdown_tbl[s] = countdown_tbl[s] - 16'd1;
            if (countdown_tbl[s] == '0) begin
              countdown_tbl[s] = period_tbl[s];
              if (handler_tbl[s]) begin
                any_fired = 1'b1;
                if (s < MASK_W) res.fired_mask[s] = 1'b1;
              end
            end
          end
        end
        res.idle = ~any_fired;
      end
      CMD_CREATE: begin
        if (idx >= TASK_SLOTS) begin
          res.status = ST_BAD_SLOT;
        end else if (!req.has_handler) begin
          res.status = ST_NO_HANDLER;
        end else begin
          period_tbl[idx] = req.period;
          countdown_tbl[idx] = 16'd1;
          handler_tbl[idx] = 1'b1;
          mode_tbl[idx] = MODE_READY;
        end
      end
      CMD_DELETE: begin
        if (idx >= TASK_SLOTS) begin
          res.status = ST_BAD_SLOT;
        end else if (!handler_tbl[idx]) begin
          res.status = ST_NO_HANDLER;
        end else begin
          handler_tbl[idx] = 1'b0;
          mode_tbl[idx] = MODE_REMOVED;
          period_tbl[idx] = '0;
          countdown_tbl[idx] = '0;
        end
      end
      CMD_SUSPEND, CMD_RESUME, CMD_WAIT: begin
        if (idx >= TASK_SLOTS) begin
          res.status = ST_BAD_SLOT;
        end else if (req.command == CMD_SUSPEND) begin
          mode_tbl[idx] = MODE_SUSPENDED;
        end else if (req.command == CMD_RESUME) begin
          mode_tbl[idx] = MODE_READY;
        end else begin
          mode_tbl[idx] = MODE_WAITING;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                          logic [PERIOD_W-1:0] period, logic hh);
    request_q.push_back('{command: cmd, slot: slot, period: period, has_handler: hh});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      command_i <= '0;
      slot_i <= '0;
      period_i <= '0;
      has_handler_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(scheduler_outcome(in_flight));
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (request_q.size() == 0) begin
          start <= 1'b0;
        end else if (request_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 4);
          start <= 1'b0;
        end else begin
          in_flight = request_q.pop_front();
          start <= 1'b1;
          command_i <= in_flight.command;
          slot_i <= in_flight.slot;
          period_i <= in_flight.period;
          has_handler_i <= in_flight.has_handler;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $error("Result strobe with no request outstanding.");
        err_cnt++;
      end else begin
        seen_exp = outcome_q.pop_front();
        if (status_o !== seen_exp.status) begin
          $error("status: expected %0d, actual %0d", seen_exp.status, status_o);
          err_cnt++;
        end
        if (fired_mask_o !== seen_exp.fired_mask) begin
          $error("fired_mask: expected 0x%02h, actual 0x%02h", seen_exp.fired_mask,
                 fired_mask_o);
          err_cnt++;
        end
        if (idle_o !== seen_exp.idle) begin
          $error("idle: expected %0d, actual %0d", seen_exp.idle, idle_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [CMD_W-1:0] cmd;
    logic [SLOT_W-1:0] slot;
    logic [PERIOD_W-1:0] period;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      period_tbl[s] = '0;
      countdown_tbl[s] = '0;
      mode_tbl[s] = MODE_EMPTY;
      handler_tbl[s] = 1'b0;
    end

    push_req(CMD_TICK, 8'd0, 16'd0, 1'b0);
    push_req(CMD_CREATE, 8'd0, 16'd1, 1'b1);
    push_req(CMD_CREATE, 8'd7, 16'd0, 1'b1);
    push_req(CMD_CREATE, 8'd3, 16'hFFFF, 1'b0);
    push_req(CMD_CREATE, 8'd8, 16'd5, 1'b1);
    push_req(CMD_CREATE, 8'd255, 16'd5, 1'b1);
    push_req(CMD_TICK, 8'hFF, 16'hFFFF, 1'b1);
    push_req(CMD_TICK, 8'd0, 16'd0, 1'b0);
    push_req(CMD_SUSPEND, 8'd0, 16'd0, 1'b0);
    push_req(CMD_TICK, 8'd0, 16'd0, 1'b0);
    push_req(CMD_RESUME, 8'd0, 16'd0, 1'b0);
    push_req(CMD_WAIT, 8'd7, 16'd0, 1'b0);
    push_req(CMD_DELETE, 8'd7, 16'd0, 1'b0);
    push_req(CMD_DELETE, 8'd7, 16'd0, 1'b0);
    push_req(CMD_DELETE, 8'd200, 16'd0, 1'b1);
    push_req(CMD_RESUME, 8'd5, 16'd0, 1'b0);
    push_req(CMD_RESUME, 8'd7, 16'd0, 1'b0);
    push_req(CMD_TICK, 8'd0, 16'd0, 1'b0);
    push_req(CMD_SUSPEND, 8'd255, 16'd0, 1'b0);
    push_req(CMD_RESUME, 8'd8, 16'd0, 1'b0);
    push_req(CMD_WAIT, 8'd128, 16'd0, 1'b0);
    push_req(CMD_SPARE6, 8'd2, 16'hA5A5, 1'b1);
    push_req(CMD_SPARE7, 8'd0, 16'd0, 1'b0);
    push_req(CMD_CREATE, 8'd2, 16'd2, 1'b1);
    push_req(CMD_CREATE, 8'd2, 16'd3, 1'b1);

    // Mostly ticks, with frequent creates and mostly short periods so slots fire often.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_TICK;
      else if (pick < 60) cmd = CMD_CREATE;
      else if (pick < 70) cmd = CMD_DELETE;
      else if (pick < 78) cmd = CMD_SUSPEND;
      else if (pick < 88) cmd = CMD_RESUME;
      else if (pick < 95) cmd = CMD_WAIT;
      else cmd = $urandom_range(0, 1) ? CMD_SPARE7 : CMD_SPARE6;
      slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(0, 255))
                                         : SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) period = PERIOD_W'($urandom_range(0, 4));
      else if (pick < 8) period = PERIOD_W'($urandom_range(5, 20));
      else period = PERIOD_W'($urandom_range(0, 65535));
      push_req(cmd, slot, period, $urandom_range(0, 7) != 0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (request_q.size() != 0 || start || outcome_q.size() != 0) @(posedge clk_i);
    repeat (TASK_SLOTS + 4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("periodic_task_tick_scheduler verification clean");
    end else begin
      $display("periodic_task_tick_scheduler verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("periodic_task_tick_scheduler verification failed");
    $finish;
  end

endmodule
